### rtl/pilk_pkg.sv
// Package for the pairwise IBD locus likelihood block.
// Field widths, status and register codes, and the classification record.
// No dependencies.
package pilk_pkg;

   localparam int ALLELE_W  = 10;
   localparam int FREQ_W    = 17;
   localparam int OUT_W     = 41;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int SEL_W     = FREQ_W + 1;
   localparam int VP_W      = 2 * FREQ_W + 1;

   localparam logic [STATUS_W-1:0] STAT_COMPUTED = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_SKIPPED  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_PARTIAL  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SHARE_TWO  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARE_ONE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARE_ZERO = 2'd2;

   localparam logic [FREQ_W-1:0] SHARE_ZERO_RESET = 17'd65536;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                v_homo;
      logic                r_homo;
      logic                use_k2;
      logic                use_k1;
      logic                k1_dbl;
      logic [SEL_W-1:0]    sel;
   } pilk_class_type;

endpackage

### rtl/pairwise_ibd_locus_likelihood.sv
// Pairwise IBD likelihoods for one STR locus, six-stage multiplier pipeline.
// An accepted transaction is registered in stages s1 to s5, then in the result registers that drive rsp_valid.
// Throughput: one transaction per cycle; a stalled result freezes all stages.
// Reset clears all valid bits and loads the share registers (k0 = 1.0).
// Depends on pilk_pkg, pilk_classify and pilk_scale.
module pairwise_ibd_locus_likelihood #(
   parameter int FREQ_FRAC_BITS = 16,
   parameter int OUT_FRAC_BITS  = 40
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [pilk_pkg::ALLELE_W-1:0]   req_victim_allele_first,
   input  logic [pilk_pkg::ALLELE_W-1:0]   req_victim_allele_second,
   input  logic [pilk_pkg::ALLELE_W-1:0]   req_ref_allele_first,
   input  logic [pilk_pkg::ALLELE_W-1:0]   req_ref_allele_second,
   input  logic [pilk_pkg::FREQ_W-1:0]     req_victim_freq_first,
   input  logic [pilk_pkg::FREQ_W-1:0]     req_victim_freq_second,
   input  logic [pilk_pkg::FREQ_W-1:0]     req_ref_freq_first,
   input  logic [pilk_pkg::FREQ_W-1:0]     req_ref_freq_second,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pilk_pkg::OUT_W-1:0]      rsp_like_related,
   output logic [pilk_pkg::OUT_W-1:0]      rsp_like_unrelated,
   output logic [pilk_pkg::STATUS_W-1:0]   rsp_locus_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pilk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pilk_pkg::FREQ_W-1:0]     csr_data
);
   import pilk_pkg::*;

   localparam int F     = FREQ_FRAC_BITS;
   localparam int IW_A  = 3 * FREQ_W + 2;
   localparam int IW_B  = FREQ_W + 1 + 2 * F;
   localparam int IW_C  = 2 * FREQ_W + 2 + F;
   localparam int IW_AB = (IW_A > IW_B) ? IW_A : IW_B;
   localparam int IW    = ((IW_AB > IW_C) ? IW_AB : IW_C) + 2;
   localparam int CH_W  = 32;
   localparam int NCH   = (IW + CH_W - 1) / CH_W;
   localparam int PW    = NCH * CH_W + VP_W;
   localparam int UW    = 2 * VP_W;
   localparam logic [OUT_W-1:0] LIM =
      (OUT_FRAC_BITS < OUT_W) ? (OUT_W'(1) << OUT_FRAC_BITS) : {OUT_W{1'b1}};

   logic advance;

   logic [FREQ_W-1:0] share_two_ff, share_one_ff, share_zero_ff;
   logic [FREQ_W-1:0] share_two_in, share_one_in, share_zero_in;

   pilk_class_type          cls_in, s1_cls_ff, s2_cls_ff;
   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic                    rsp_valid_ff;
   logic [2*FREQ_W-1:0]     ab_prod, cd_prod;
   logic [VP_W-1:0]         vp_in, rp_in, s1_vp_ff, s1_rp_ff, s2_vp_ff, s3_vp_ff;
   logic [3*FREQ_W:0]       p_k0_in, s2_p_k0_ff;
   logic [VP_W-1:0]         p_k1_in, s2_p_k1_ff;
   logic [VP_W+SEL_W-1:0]   pu_lo_in, s2_pu_lo_ff;
   logic [VP_W+FREQ_W-1:0]  pu_hi_in, s2_pu_hi_ff;
   logic [IW-1:0]           inner_in, s3_inner_ff;
   logic [UW-1:0]           unrel_in, s3_unrel_ff, s4_unrel_ff, s5_unrel_ff;
   logic [STATUS_W-1:0]     s3_status_ff, s4_status_ff, s5_status_ff;
   logic [NCH*CH_W-1:0]     inner_pad;
   logic [CH_W+VP_W-1:0]    part_in [NCH];
   logic [CH_W+VP_W-1:0]    s4_part_ff [NCH];
   logic [PW-1:0]           rel_in, s5_rel_ff;
   logic [OUT_W-1:0]        rel_scaled, unrel_scaled;
   logic [OUT_W-1:0]        rel_out_in, unrel_out_in;
   logic [OUT_W-1:0]        rsp_rel_ff, rsp_unrel_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_comb begin
      share_two_in  = share_two_ff;
      share_one_in  = share_one_ff;
      share_zero_in = share_zero_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SHARE_TWO:  share_two_in  = csr_data;
            CSR_SHARE_ONE:  share_one_in  = csr_data;
            CSR_SHARE_ZERO: share_zero_in = csr_data;
            default:        share_two_in  = share_two_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         share_two_ff  <= '0;
         share_one_ff  <= '0;
         share_zero_ff <= SHARE_ZERO_RESET;
      end else begin
         share_two_ff  <= share_two_in;
         share_one_ff  <= share_one_in;
         share_zero_ff <= share_zero_in;
      end
   end

   pilk_classify u_classify (
      .victim_allele_first  (req_victim_allele_first),
      .victim_allele_second (req_victim_allele_second),
      .ref_allele_first     (req_ref_allele_first),
      .ref_allele_second    (req_ref_allele_second),
      .ref_freq_first       (req_ref_freq_first),
      .ref_freq_second      (req_ref_freq_second),
      .cls                  (cls_in)
   );

   // stage 1: genotype probabilities
   always_comb begin
      ab_prod = req_victim_freq_first * req_victim_freq_second;
      cd_prod = req_ref_freq_first * req_ref_freq_second;
      vp_in   = cls_in.v_homo ? {1'b0, ab_prod} : {ab_prod, 1'b0};
      rp_in   = cls_in.r_homo ? {1'b0, cd_prod} : {cd_prod, 1'b0};
   end

   // stage 2: share products and split unrelated product
   always_comb begin
      p_k0_in  = s1_rp_ff * share_zero_ff;
      p_k1_in  = s1_cls_ff.sel * share_one_ff;
      pu_lo_in = s1_vp_ff * s1_rp_ff[SEL_W-1:0];
      pu_hi_in = s1_vp_ff * s1_rp_ff[VP_W-1:SEL_W];
   end

   // stage 3: bracket sum
   always_comb begin
      inner_in = IW'(s2_p_k0_ff) << 1;
      if (s2_cls_ff.use_k2) begin
         inner_in = inner_in + (IW'(share_two_ff) << (2 * F + 1));
      end
      if (s2_cls_ff.use_k1) begin
         inner_in = inner_in + ((IW'(s2_p_k1_ff) << F) << s2_cls_ff.k1_dbl);
      end
      unrel_in = UW'(s2_pu_lo_ff) + (UW'(s2_pu_hi_ff) << SEL_W);
   end

   // stage 4: partial products of the related likelihood
   assign inner_pad = (NCH*CH_W)'(s3_inner_ff);

   for (genvar i = 0; i < NCH; i++) begin : g_part
      assign part_in[i] = inner_pad[i*CH_W +: CH_W] * s3_vp_ff;
   end

   // stage 5: sum partial products
   always_comb begin
      rel_in = '0;
      for (int i = 0; i < NCH; i++) begin
         rel_in = rel_in + (PW'(s4_part_ff[i]) << (CH_W * i));
      end
   end

   // stage 6: rescale, saturate, special cases
   pilk_scale #(
      .IN_W     (PW),
      .IN_FRAC  (5 * F + 1),
      .OUT_FRAC (OUT_FRAC_BITS)
   ) u_scale_rel (
      .din  (s5_rel_ff),
      .dout (rel_scaled)
   );

   pilk_scale #(
      .IN_W     (UW),
      .IN_FRAC  (4 * F),
      .OUT_FRAC (OUT_FRAC_BITS)
   ) u_scale_unrel (
      .din  (s5_unrel_ff),
      .dout (unrel_scaled)
   );

   always_comb begin
      case (s5_status_ff)
         STAT_COMPUTED: begin
            rel_out_in   = rel_scaled;
            unrel_out_in = unrel_scaled;
         end
         STAT_SKIPPED: begin
            rel_out_in   = LIM;
            unrel_out_in = LIM;
         end
         default: begin
            rel_out_in   = '0;
            unrel_out_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cls_ff     <= cls_in;
         s1_vp_ff      <= vp_in;
         s1_rp_ff      <= rp_in;
         s2_cls_ff     <= s1_cls_ff;
         s2_vp_ff      <= s1_vp_ff;
         s2_p_k0_ff    <= p_k0_in;
         s2_p_k1_ff    <= p_k1_in;
         s2_pu_lo_ff   <= pu_lo_in;
         s2_pu_hi_ff   <= pu_hi_in;
         s3_status_ff  <= s2_cls_ff.status;
         s3_vp_ff      <= s2_vp_ff;
         s3_inner_ff   <= inner_in;
         s3_unrel_ff   <= unrel_in;
         s4_status_ff  <= s3_status_ff;
         s4_part_ff    <= part_in;
         s4_unrel_ff   <= s3_unrel_ff;
         s5_status_ff  <= s4_status_ff;
         s5_rel_ff     <= rel_in;
         s5_unrel_ff   <= s4_unrel_ff;
         rsp_rel_ff    <= rel_out_in;
         rsp_unrel_ff  <= unrel_out_in;
         rsp_status_ff <= s5_status_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_like_related   = rsp_rel_ff;
   assign rsp_like_unrelated = rsp_unrel_ff;
   assign rsp_locus_status   = rsp_status_ff;

   a_skip_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_locus_status == STAT_SKIPPED) |->
         (rsp_like_related == LIM) && (rsp_like_unrelated == LIM))
      else $error("skipped locus without unit likelihoods");

   a_partial_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_locus_status == STAT_PARTIAL) |->
         (rsp_like_related == '0) && (rsp_like_unrelated == '0))
      else $error("partial drop-out with nonzero likelihood");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_like_related <= LIM) && (rsp_like_unrelated <= LIM))
      else $error("likelihood above saturation limit");

   a_no_hold_bubble: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(s5_valid_ff) && $stable(s1_valid_ff)))
      else $error("pipeline valid moved during stall");

endmodule

### rtl/pilk_classify.sv
// Allele pair ordering and allele-sharing classification for one locus.
// Depends on pilk_pkg.
module pilk_classify (
   input  logic [pilk_pkg::ALLELE_W-1:0] victim_allele_first,
   input  logic [pilk_pkg::ALLELE_W-1:0] victim_allele_second,
   input  logic [pilk_pkg::ALLELE_W-1:0] ref_allele_first,
   input  logic [pilk_pkg::ALLELE_W-1:0] ref_allele_second,
   input  logic [pilk_pkg::FREQ_W-1:0]   ref_freq_first,
   input  logic [pilk_pkg::FREQ_W-1:0]   ref_freq_second,
   output pilk_pkg::pilk_class_type      cls
);
   import pilk_pkg::*;

   logic [ALLELE_W-1:0] v0, v1, r0, r1;
   logic [FREQ_W-1:0]   fc, fd;
   logic                absent, partial, pr1, pr2, equal;

   always_comb begin
      absent  = ((victim_allele_first == '0) && (victim_allele_second == '0)) ||
                ((ref_allele_first == '0) && (ref_allele_second == '0));
      partial = (victim_allele_first == '0) || (victim_allele_second == '0) ||
                (ref_allele_first == '0) || (ref_allele_second == '0);
      if (victim_allele_first > victim_allele_second) begin
         v0 = victim_allele_second;
         v1 = victim_allele_first;
      end else begin
         v0 = victim_allele_first;
         v1 = victim_allele_second;
      end
      if (ref_allele_first > ref_allele_second) begin
         r0 = ref_allele_second;
         r1 = ref_allele_first;
         fc = ref_freq_second;
         fd = ref_freq_first;
      end else begin
         r0 = ref_allele_first;
         r1 = ref_allele_second;
         fc = ref_freq_first;
         fd = ref_freq_second;
      end
      cls.v_homo = (v0 == v1);
      cls.r_homo = (r0 == r1);
      pr1   = (r0 == v0) || (r0 == v1);
      pr2   = (r1 == v0) || (r1 == v1);
      equal = (cls.v_homo == cls.r_homo) && (v0 == r0) && (v1 == r1);

      if (absent) begin
         cls.status = STAT_SKIPPED;
      end else if (partial) begin
         cls.status = STAT_PARTIAL;
      end else begin
         cls.status = STAT_COMPUTED;
      end

      cls.use_k2 = 1'b0;
      cls.use_k1 = 1'b0;
      cls.k1_dbl = 1'b0;
      cls.sel    = '0;
      if (!pr1 && !pr2) begin
         cls.use_k1 = 1'b0;
      end else if (equal) begin
         cls.use_k2 = 1'b1;
         cls.use_k1 = 1'b1;
         cls.sel    = SEL_W'(fc) + SEL_W'(fd);
      end else if (!cls.v_homo && !cls.r_homo) begin
         cls.use_k1 = 1'b1;
         cls.sel    = SEL_W'(pr1 ? fd : fc);
      end else if (cls.r_homo) begin
         cls.use_k1 = 1'b1;
         cls.sel    = SEL_W'(fc);
      end else begin
         cls.use_k1 = 1'b1;
         cls.k1_dbl = 1'b1;
         cls.sel    = SEL_W'(pr1 ? fd : fc);
      end
   end

endmodule

### rtl/pilk_scale.sv
// Fixed-point rescale to the output format: truncate, then saturate at 1.0.
// Depends on pilk_pkg.
module pilk_scale #(
   parameter int IN_W     = 70,
   parameter int IN_FRAC  = 64,
   parameter int OUT_FRAC = 40
) (
   input  logic [IN_W-1:0]            din,
   output logic [pilk_pkg::OUT_W-1:0] dout
);
   import pilk_pkg::*;

   localparam int LSH = (OUT_FRAC > IN_FRAC) ? (OUT_FRAC - IN_FRAC) : 0;
   localparam int RSH = (IN_FRAC > OUT_FRAC) ? (IN_FRAC - OUT_FRAC) : 0;
   localparam int SW  = IN_W + LSH;
   localparam logic [OUT_W-1:0] LIM =
      (OUT_FRAC < OUT_W) ? (OUT_W'(1) << OUT_FRAC) : {OUT_W{1'b1}};

   logic [SW-1:0] shifted;

   always_comb begin
      shifted = (SW'(din) << LSH) >> RSH;
      if (shifted > SW'(LIM)) begin
         dout = LIM;
      end else begin
         dout = shifted[OUT_W-1:0];
      end
   end

endmodule

### sim/pilk_locus_checker.sv
`timescale 1ns / 100ps
// Checker for the pairwise IBD locus likelihood block: predicts both likelihoods and
// the locus status of every accepted transaction and compares each result in order.
// Depends on pilk_pkg; instantiated beside the block by the testbench top.
module pilk_locus_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [pilk_pkg::ALLELE_W-1:0]   req_victim_allele_first,
   input  logic [pilk_pkg::ALLELE_W-1:0]   req_victim_allele_second,
   input  logic [pilk_pkg::ALLELE_W-1:0]   req_ref_allele_first,
   input  logic [pilk_pkg::ALLELE_W-1:0]   req_ref_allele_second,
   input  logic [pilk_pkg::FREQ_W-1:0]     req_victim_freq_first,
   input  logic [pilk_pkg::FREQ_W-1:0]     req_victim_freq_second,
   input  logic [pilk_pkg::FREQ_W-1:0]     req_ref_freq_first,
   input  logic [pilk_pkg::FREQ_W-1:0]     req_ref_freq_second,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [pilk_pkg::OUT_W-1:0]      rsp_like_related,
   input  logic [pilk_pkg::OUT_W-1:0]      rsp_like_unrelated,
   input  logic [pilk_pkg::STATUS_W-1:0]   rsp_locus_status,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [pilk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pilk_pkg::FREQ_W-1:0]     csr_data,
   output int                              mismatch_count,
   output int                              pending_count
);
   import pilk_pkg::*;

   localparam int FRAC        = 16;
   localparam int OUT_FRAC    = 40;
   localparam int REL_SHIFT   = 5 * FRAC + 1 - OUT_FRAC;
   localparam int UNREL_SHIFT = 4 * FRAC - OUT_FRAC;
   localparam logic [127:0] LIKE_ONE = 128'd1 << OUT_FRAC;

   typedef struct {
      logic [OUT_W-1:0]    related;
      logic [OUT_W-1:0]    unrelated;
      logic [STATUS_W-1:0] status;
   } likelihood_type;

   logic [FREQ_W-1:0] share_two;
   logic [FREQ_W-1:0] share_one;
   logic [FREQ_W-1:0] share_zero;
   likelihood_type    awaited_likelihoods[$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic logic [OUT_W-1:0] clip_to_one(input logic [127:0] value);
      return (value > LIKE_ONE) ? LIKE_ONE[OUT_W-1:0] : value[OUT_W-1:0];
   endfunction

   function automatic likelihood_type predict_likelihoods(
      input logic [ALLELE_W-1:0] v_lo, v_hi, r_lo, r_hi,
      input logic [FREQ_W-1:0]   f_vlo, f_vhi, f_rlo, f_rhi
   );
      likelihood_type    res;
      logic [127:0]      vp;
      logic [127:0]      rp;
      logic [127:0]      bracket;
      logic [FREQ_W-1:0] f_other;
      logic              v_homo, r_homo, sh_lo, sh_hi, same;
      if ((v_lo == 0 && v_hi == 0) || (r_lo == 0 && r_hi == 0)) begin
         res.related   = LIKE_ONE[OUT_W-1:0];
         res.unrelated = LIKE_ONE[OUT_W-1:0];
         res.status    = STAT_SKIPPED;
         return res;
      end
      if (v_lo == 0 || v_hi == 0 || r_lo == 0 || r_hi == 0) begin
         res.related   = '0;
         res.unrelated = '0;
         res.status    = STAT_PARTIAL;
         return res;
      end
      // sort each pair; ties keep their input order
      if (v_lo > v_hi) begin
         {v_lo, v_hi}   = {v_hi, v_lo};
         {f_vlo, f_vhi} = {f_vhi, f_vlo};
      end
      if (r_lo > r_hi) begin
         {r_lo, r_hi}   = {r_hi, r_lo};
         {f_rlo, f_rhi} = {f_rhi, f_rlo};
      end
      v_homo = (v_lo == v_hi);
      r_homo = (r_lo == r_hi);
      sh_lo  = (r_lo == v_lo) || (r_lo == v_hi);
      sh_hi  = (r_hi == v_lo) || (r_hi == v_hi);
      same   = (v_lo == r_lo) && (v_hi == r_hi);
      vp = 128'(f_vlo) * 128'(f_vhi);
      rp = 128'(f_rlo) * 128'(f_rhi);
      if (!v_homo) vp = vp << 1;
      if (!r_homo) rp = rp << 1;
      bracket = (rp * 128'(share_zero)) << 1;
      if (!sh_lo && !sh_hi) begin
      end else if (same) begin
         bracket = bracket + (128'(share_two) << (2 * FRAC + 1));
         bracket = bracket + (((128'(f_rlo) + 128'(f_rhi)) * 128'(share_one)) << FRAC);
      end else if (!v_homo && !r_homo) begin
         f_other = sh_lo ? f_rhi : f_rlo;
         bracket = bracket + ((128'(f_other) * 128'(share_one)) << FRAC);
      end else if (r_homo) begin
         bracket = bracket + ((128'(f_rlo) * 128'(share_one)) << FRAC);
      end else begin
         f_other = sh_lo ? f_rhi : f_rlo;
         bracket = bracket + ((128'(f_other) * 128'(share_one)) << (FRAC + 1));
      end
      res.related   = clip_to_one((bracket * vp) >> REL_SHIFT);
      res.unrelated = clip_to_one((vp * rp) >> UNREL_SHIFT);
      res.status    = STAT_COMPUTED;
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $time, field, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      likelihood_type head;
      if (reset) begin
         share_two  = '0;
         share_one  = '0;
         share_zero = SHARE_ZERO_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SHARE_TWO:  share_two  = csr_data;
               CSR_SHARE_ONE:  share_one  = csr_data;
               CSR_SHARE_ZERO: share_zero = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_likelihoods.size() == 0) begin
               report_mismatch("unrequested result, like_related",
                               64'(rsp_like_related), '0);
            end else begin
               head = awaited_likelihoods.pop_front();
               if (rsp_like_related !== head.related)
                  report_mismatch("like_related", 64'(rsp_like_related),
                                  64'(head.related));
               if (rsp_like_unrelated !== head.unrelated)
                  report_mismatch("like_unrelated", 64'(rsp_like_unrelated),
                                  64'(head.unrelated));
               if (rsp_locus_status !== head.status)
                  report_mismatch("locus_status", 64'(rsp_locus_status),
                                  64'(head.status));
            end
         end
         if (req_valid && !req_stall) begin
            awaited_likelihoods.push_back(predict_likelihoods(
               req_victim_allele_first, req_victim_allele_second,
               req_ref_allele_first, req_ref_allele_second,
               req_victim_freq_first, req_victim_freq_second,
               req_ref_freq_first, req_ref_freq_second));
         end
      end
      pending_count = awaited_likelihoods.size();
   end

endmodule

### sim/pairwise_ibd_locus_likelihood_tb.sv
`timescale 1ns / 100ps
// Testbench top for the pairwise IBD locus likelihood block: drives directed and
// random loci through several share settings and idle patterns, and gives the verdict.
// Depends on pilk_pkg, pilk_locus_checker and the block itself.
module pairwise_ibd_locus_likelihood_tb;
   import pilk_pkg::*;

   localparam int                    QUIET_LIMIT = 5000;
   localparam logic [FREQ_W-1:0]     FREQ_ONE    = 17'd65536;
   localparam logic [FREQ_W-1:0]     FREQ_MAX    = 17'd131071;
   localparam logic [CSR_IDX_W-1:0]  CSR_UNUSED  = 2'd3;

   typedef struct packed {
      logic [ALLELE_W-1:0] victim_first;
      logic [ALLELE_W-1:0] victim_second;
      logic [ALLELE_W-1:0] ref_first;
      logic [ALLELE_W-1:0] ref_second;
      logic [FREQ_W-1:0]   victim_freq_first;
      logic [FREQ_W-1:0]   victim_freq_second;
      logic [FREQ_W-1:0]   ref_freq_first;
      logic [FREQ_W-1:0]   ref_freq_second;
   } locus_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [ALLELE_W-1:0]   req_victim_allele_first;
   logic [ALLELE_W-1:0]   req_victim_allele_second;
   logic [ALLELE_W-1:0]   req_ref_allele_first;
   logic [ALLELE_W-1:0]   req_ref_allele_second;
   logic [FREQ_W-1:0]     req_victim_freq_first;
   logic [FREQ_W-1:0]     req_victim_freq_second;
   logic [FREQ_W-1:0]     req_ref_freq_first;
   logic [FREQ_W-1:0]     req_ref_freq_second;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [OUT_W-1:0]      rsp_like_related;
   logic [OUT_W-1:0]      rsp_like_unrelated;
   logic [STATUS_W-1:0]   rsp_locus_status;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [FREQ_W-1:0]     csr_data;
   int                    mismatch_count;
   int                    pending_count;
   int                    send_idle_pct;
   int                    stall_pct;
   int                    quiet_cycles;

   pairwise_ibd_locus_likelihood i_dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_victim_allele_first  (req_victim_allele_first),
      .req_victim_allele_second (req_victim_allele_second),
      .req_ref_allele_first     (req_ref_allele_first),
      .req_ref_allele_second    (req_ref_allele_second),
      .req_victim_freq_first    (req_victim_freq_first),
      .req_victim_freq_second   (req_victim_freq_second),
      .req_ref_freq_first       (req_ref_freq_first),
      .req_ref_freq_second      (req_ref_freq_second),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_like_related         (rsp_like_related),
      .rsp_like_unrelated       (rsp_like_unrelated),
      .rsp_locus_status         (rsp_locus_status),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data)
   );

   pilk_locus_checker i_checker (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_victim_allele_first  (req_victim_allele_first),
      .req_victim_allele_second (req_victim_allele_second),
      .req_ref_allele_first     (req_ref_allele_first),
      .req_ref_allele_second    (req_ref_allele_second),
      .req_victim_freq_first    (req_victim_freq_first),
      .req_victim_freq_second   (req_victim_freq_second),
      .req_ref_freq_first       (req_ref_freq_first),
      .req_ref_freq_second      (req_ref_freq_second),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_like_related         (rsp_like_related),
      .rsp_like_unrelated       (rsp_like_unrelated),
      .rsp_locus_status         (rsp_locus_status),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data),
      .mismatch_count           (mismatch_count),
      .pending_count            (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic locus_type make_locus(
      input int v0, v1, r0, r1,
      input int fa, fb, fc, fd
   );
      return '{ALLELE_W'(v0), ALLELE_W'(v1), ALLELE_W'(r0), ALLELE_W'(r1),
               FREQ_W'(fa), FREQ_W'(fb), FREQ_W'(fc), FREQ_W'(fd)};
   endfunction

   function automatic locus_type random_locus();
      int                  kind;
      int                  base;
      int                  slot;
      logic [ALLELE_W-1:0] al [4];
      logic [FREQ_W-1:0]   fr [4];
      kind = $urandom_range(0, 99);
      base = $urandom_range(1, 1021);
      for (int i = 0; i < 4; i++) begin
         if (kind < 12)
            al[i] = ALLELE_W'($urandom_range(0, 1023));
         else
            al[i] = ALLELE_W'(base + $urandom_range(0, 2));
         case ($urandom_range(0, 9))
            0: fr[i] = FREQ_W'($urandom_range(0, 131071));
            1: fr[i] = $urandom_range(0, 1) ? FREQ_ONE : '0;
            default: fr[i] = FREQ_W'($urandom_range(1, 65535));
         endcase
      end
      if (kind >= 12 && kind < 18) begin
         slot = $urandom_range(0, 3);
         al[slot] = '0;
      end else if (kind >= 18 && kind < 23) begin
         slot = $urandom_range(0, 2);
         if (slot != 1) {al[0], al[1]} = '0;
         if (slot != 0) {al[2], al[3]} = '0;
      end
      return '{al[0], al[1], al[2], al[3], fr[0], fr[1], fr[2], fr[3]};
   endfunction

   task automatic send_locus(input locus_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid                <= 1'b1;
      req_victim_allele_first  <= it.victim_first;
      req_victim_allele_second <= it.victim_second;
      req_ref_allele_first     <= it.ref_first;
      req_ref_allele_second    <= it.ref_second;
      req_victim_freq_first    <= it.victim_freq_first;
      req_victim_freq_second   <= it.victim_freq_second;
      req_ref_freq_first       <= it.ref_freq_first;
      req_ref_freq_second      <= it.ref_freq_second;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_shares(input logic [FREQ_W-1:0] two, one, zero);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [FREQ_W-1:0]    val [4];
      idx = '{CSR_SHARE_TWO, CSR_SHARE_ONE, CSR_SHARE_ZERO, CSR_UNUSED};
      val = '{two, one, zero, FREQ_W'($urandom_range(0, 131071))};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic apply_shares(input int setting);
      case (setting)
         0: write_shares(17'd16384, 17'd32768, 17'd16384);
         1: write_shares('0, FREQ_ONE, '0);
         2: write_shares('0, '0, FREQ_ONE);
         3: write_shares(FREQ_ONE, FREQ_ONE, FREQ_ONE);
         4: write_shares(FREQ_MAX, FREQ_MAX, FREQ_MAX);
         5: write_shares('0, '0, '0);
         6: write_shares(FREQ_W'($urandom_range(0, 131071)),
                         FREQ_W'($urandom_range(0, 131071)),
                         FREQ_W'($urandom_range(0, 131071)));
         default: write_shares(FREQ_W'($urandom_range(0, 65536)),
                               FREQ_W'($urandom_range(0, 65536)),
                               FREQ_W'($urandom_range(0, 65536)));
      endcase
   endtask

   initial begin
      reset                    = 1'b1;
      req_valid                = 1'b0;
      req_victim_allele_first  = '0;
      req_victim_allele_second = '0;
      req_ref_allele_first     = '0;
      req_ref_allele_second    = '0;
      req_victim_freq_first    = '0;
      req_victim_freq_second   = '0;
      req_ref_freq_first       = '0;
      req_ref_freq_second      = '0;
      csr_valid                = 1'b0;
      csr_index                = '0;
      csr_data                 = '0;
      send_idle_pct            = 0;
      stall_pct                = 0;
      quiet_cycles             = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // shares at their reset values
      for (int n = 0; n < 30; n++) send_locus(random_locus());
      wait_drained();

      apply_shares(0);
      send_locus(make_locus(0, 0, 150, 160, 1000, 2000, 3000, 4000));
      send_locus(make_locus(120, 130, 0, 0, 1000, 2000, 3000, 4000));
      send_locus(make_locus(0, 0, 0, 0, 1000, 2000, 3000, 4000));
      send_locus(make_locus(0, 130, 150, 160, 1000, 2000, 3000, 4000));
      send_locus(make_locus(120, 130, 150, 0, 1000, 2000, 3000, 4000));
      send_locus(make_locus(120, 130, 140, 150, 5000, 6000, 7000, 8000));
      send_locus(make_locus(130, 120, 130, 120, 5000, 6000, 7000, 8000));
      send_locus(make_locus(110, 110, 110, 110, 9000, 9500, 8000, 8500));
      send_locus(make_locus(120, 130, 120, 150, 5000, 6000, 7000, 8000));
      send_locus(make_locus(120, 130, 110, 130, 5000, 6000, 7000, 8000));
      send_locus(make_locus(120, 130, 130, 130, 7000, 8000, 9000, 9500));
      send_locus(make_locus(140, 140, 120, 140, 9000, 9100, 3000, 4000));
      send_locus(make_locus(140, 140, 140, 150, 9000, 9100, 3000, 4000));
      send_locus(make_locus(140, 140, 150, 150, 3000, 5000, 7000, 2000));
      send_locus(make_locus(1023, 1023, 1023, 1023, FREQ_MAX, FREQ_MAX, FREQ_MAX, FREQ_MAX));
      send_locus(make_locus(200, 210, 210, 200, FREQ_ONE, FREQ_ONE, FREQ_ONE, FREQ_ONE));
      send_locus(make_locus(200, 210, 210, 200, 0, 0, 0, 0));
      send_locus(make_locus(1, 1000, 1000, 1, 1, 2, 3, 4));
      send_locus(make_locus(512, 256, 256, 512, 43690, 21845, 21845, 43690));
      send_locus(make_locus(175, 180, 190, 175, 65535, 1, 32768, 16384));
      send_locus(make_locus(1023, 1, 1, 1023, 131070, 65537, 98304, 1));

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 50; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 50; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         wait_drained();
         apply_shares((phase + 1) % 8);
         for (int n = 0; n < 175; n++) begin
            // hold off until the pipeline is empty
            if (n == 87) wait_drained();
            send_locus(random_locus());
         end
      end

      wait_drained();
      repeat (12) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
